@@ design/ili_pkg.sv @@
// Package with the types, constants and codes shared by the interval list intersection block.
package ili_pkg;

    localparam int LIST_DEPTH  = 16;
    localparam int KEY_BITS    = 32;
    localparam int FIELD_BITS  = 32;
    localparam int MAX_RESULTS = 31;

    localparam int ADDR_BITS = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(LIST_DEPTH + 1);
    localparam int RES_BITS  = $clog2(MAX_RESULTS + 1);

    typedef logic [KEY_BITS-1:0]  key_t;
    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;
    typedef logic [RES_BITS-1:0]  res_cnt_t;

    typedef enum logic [1:0] {
        KIND_LOAD_A  = 2'd0,
        KIND_LOAD_B  = 2'd1,
        KIND_COMPUTE = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic {
        WALK_IDLE = 1'b0,
        WALK_RUN  = 1'b1
    } walk_state_t;

    // One stored interval.
    typedef struct packed {
        key_t upper;
        key_t lower;
    } entry_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [FIELD_BITS-1:0] lower_end;
        logic [FIELD_BITS-1:0] upper_end;
    } in_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] out_lower;
        logic [FIELD_BITS-1:0] out_upper;
        logic                  is_last;
        logic                  none_found;
        logic                  overflowed;
    } out_t;

    // Start command handed from the load side to the merge walker.
    typedef struct packed {
        logic start;
        cnt_t count_a;
        cnt_t count_b;
        logic overflow;
    } walk_cmd_t;

endpackage

@@ design/ili_list_ram.sv @@
// Synchronous single-write, single-read memory holding one interval list.
module ili_list_ram
    import ili_pkg::*;
(
    input  logic   clk,
    input  logic   wr_en,
    input  addr_t  wr_addr,
    input  entry_t wr_data,
    input  addr_t  rd_addr,
    output entry_t rd_data
);

    entry_t mem [LIST_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/ili_walk.sv @@
// Two-pointer merge walker that reads both list memories and produces intersection results.
module ili_walk
    import ili_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  walk_cmd_t cmd,
    input  entry_t    a_data,
    input  entry_t    b_data,
    output addr_t     a_rd_addr,
    output addr_t     b_rd_addr,
    input  logic      out_free,
    output logic      push,
    output out_t      push_item,
    output logic      busy
);

    walk_state_t state_reg, state_next;
    cnt_t        ia_reg, ia_next;
    cnt_t        ib_reg, ib_next;
    res_cnt_t    k_reg, k_next;
    logic        sel_reg, sel_next;
    logic        hold_valid_reg, hold_valid_next;
    entry_t      hold_reg, hold_next;
    cnt_t        cnt_a_reg, cnt_a_next;
    cnt_t        cnt_b_reg, cnt_b_next;
    logic        ovf_reg, ovf_next;

    entry_t f_pre, s_pre, fe, se, emit_val;
    logic   swap, sel_new, emit, adv_f, adv_s, adv_a, adv_b, cont, commit;

    // One merge step on the two entries at the current indices.
    always_comb
    begin
        f_pre   = sel_reg ? b_data : a_data;
        s_pre   = sel_reg ? a_data : b_data;
        swap    = f_pre.lower > s_pre.lower;
        sel_new = sel_reg ^ swap;
        fe      = swap ? s_pre : f_pre;
        se      = swap ? f_pre : s_pre;

        emit           = 1'b1;
        adv_f          = 1'b0;
        adv_s          = 1'b0;
        emit_val.lower = se.lower;
        emit_val.upper = se.upper;
        priority if (fe.upper < se.lower)
        begin
            emit  = 1'b0;
            adv_f = 1'b1;
        end
        else if (fe.upper == se.lower)
        begin
            emit_val.upper = se.lower;
            adv_f          = 1'b1;
        end
        else if (fe.upper == se.upper)
        begin
            adv_f = 1'b1;
            adv_s = 1'b1;
        end
        else if (fe.upper < se.upper)
        begin
            emit_val.upper = fe.upper;
            adv_f          = 1'b1;
        end
        else
        begin
            adv_s = 1'b1;
        end

        adv_a = sel_new ? adv_s : adv_f;
        adv_b = sel_new ? adv_f : adv_s;
    end

    always_comb
    begin
        state_next      = state_reg;
        ia_next         = ia_reg;
        ib_next         = ib_reg;
        k_next          = k_reg;
        sel_next        = sel_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        cnt_a_next      = cnt_a_reg;
        cnt_b_next      = cnt_b_reg;
        ovf_next        = ovf_reg;
        push            = 1'b0;
        commit          = 1'b0;

        push_item.out_lower  = FIELD_BITS'(hold_reg.lower);
        push_item.out_upper  = FIELD_BITS'(hold_reg.upper);
        push_item.is_last    = 1'b0;
        push_item.none_found = 1'b0;
        push_item.overflowed = ovf_reg;

        cont = (ia_reg < cnt_a_reg) && (ib_reg < cnt_b_reg)
               && (k_reg < RES_BITS'(MAX_RESULTS));

        unique case (state_reg)
            WALK_IDLE:
            begin
                ia_next = '0;
                ib_next = '0;
                if (cmd.start)
                begin
                    state_next      = WALK_RUN;
                    k_next          = '0;
                    sel_next        = 1'b0;
                    hold_valid_next = 1'b0;
                    cnt_a_next      = cmd.count_a;
                    cnt_b_next      = cmd.count_b;
                    ovf_next        = cmd.overflow;
                end
            end
            WALK_RUN:
            begin
                if (cont)
                begin
                    // A new result displaces the held one, which needs a free output.
                    commit = !(emit && hold_valid_reg && !out_free);
                    if (commit)
                    begin
                        push     = emit && hold_valid_reg;
                        ia_next  = adv_a ? ia_reg + 1'b1 : ia_reg;
                        ib_next  = adv_b ? ib_reg + 1'b1 : ib_reg;
                        sel_next = sel_new;
                        if (emit)
                        begin
                            hold_next       = emit_val;
                            hold_valid_next = 1'b1;
                            k_next          = k_reg + 1'b1;
                        end
                    end
                end
                else if (out_free)
                begin
                    // Walk over: release the held result as the last one, or report empty.
                    push              = 1'b1;
                    push_item.is_last = 1'b1;
                    if (!hold_valid_reg)
                    begin
                        push_item.out_lower  = '0;
                        push_item.out_upper  = '0;
                        push_item.none_found = 1'b1;
                    end
                    hold_valid_next = 1'b0;
                    state_next      = WALK_IDLE;
                end
            end
            default:
            begin
                state_next = WALK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= WALK_IDLE;
            ia_reg         <= '0;
            ib_reg         <= '0;
            k_reg          <= '0;
            sel_reg        <= 1'b0;
            hold_valid_reg <= 1'b0;
            cnt_a_reg      <= '0;
            cnt_b_reg      <= '0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ia_reg         <= ia_next;
            ib_reg         <= ib_next;
            k_reg          <= k_next;
            sel_reg        <= sel_next;
            hold_valid_reg <= hold_valid_next;
            cnt_a_reg      <= cnt_a_next;
            cnt_b_reg      <= cnt_b_next;
            ovf_reg        <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    // Reads are issued with the next indices, so data for the current indices is ready.
    assign a_rd_addr = ia_next[ADDR_BITS-1:0];
    assign b_rd_addr = ib_next[ADDR_BITS-1:0];
    assign busy      = (state_reg == WALK_RUN);

endmodule

@@ design/interval_list_intersection_core.sv @@
// Top level of the sorted interval list intersection block.
//
//  channel  | direction | payload | handshake
//  ---------+-----------+---------+------------------------------
//  item     | in        | in_t    | item_valid / item_stall
//  result   | out       | out_t   | result_valid / result_stall
//
// Loads (list A or list B) and the unused kind are accepted while no walk runs. A compute
// starts the walker, which runs merge steps (at most count_a + count_b steps, ending early
// at MAX_RESULTS results) and then releases the final result; result-side stalls hold it.
// Each merge step uses one entry of each list memory.
// item_stall is high while a compute run is in progress. Reset clears counts and
// the overflow flag; the list memories are not cleared and only written entries are used.
module interval_list_intersection_core
    import ili_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    output logic item_stall,
    input  in_t  item,
    output logic result_valid,
    input  logic result_stall,
    output out_t result
);

    cnt_t count_a_reg, count_a_next;
    cnt_t count_b_reg, count_b_next;
    logic overflow_reg, overflow_next;
    logic out_valid_reg, out_valid_next;
    out_t out_reg;

    logic      accept;
    key_t      key_lo, key_hi;
    entry_t    wr_entry;
    logic      wr_en_a, wr_en_b;
    walk_cmd_t cmd;
    addr_t     a_rd_addr, b_rd_addr;
    entry_t    a_data, b_data;
    logic      out_free, push, busy;
    out_t      push_item;

    assign accept = item_valid && !item_stall;

    // Keys are cut to the key width, and an end below its start is raised to the start.
    assign key_lo         = item.lower_end[KEY_BITS-1:0];
    assign key_hi         = item.upper_end[KEY_BITS-1:0];
    assign wr_entry.lower = key_lo;
    assign wr_entry.upper = (key_hi < key_lo) ? key_lo : key_hi;

    always_comb
    begin
        count_a_next  = count_a_reg;
        count_b_next  = count_b_reg;
        overflow_next = overflow_reg;
        wr_en_a       = 1'b0;
        wr_en_b       = 1'b0;
        cmd.start     = 1'b0;
        cmd.count_a   = count_a_reg;
        cmd.count_b   = count_b_reg;
        cmd.overflow  = overflow_reg;

        if (accept)
        begin
            unique case (kind_t'(item.kind))
                KIND_LOAD_A:
                begin
                    if (count_a_reg < CNT_BITS'(LIST_DEPTH))
                    begin
                        wr_en_a      = 1'b1;
                        count_a_next = count_a_reg + 1'b1;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                end
                KIND_LOAD_B:
                begin
                    if (count_b_reg < CNT_BITS'(LIST_DEPTH))
                    begin
                        wr_en_b      = 1'b1;
                        count_b_next = count_b_reg + 1'b1;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                end
                KIND_COMPUTE:
                begin
                    // The walker captures counts and the flag, so they clear right away.
                    cmd.start     = 1'b1;
                    count_a_next  = '0;
                    count_b_next  = '0;
                    overflow_next = 1'b0;
                end
                default:
                begin
                    // The unused kind is taken and ignored.
                end
            endcase
        end
    end

    // Loads write at their own accept edge, which always comes before the edge that
    // accepts the compute and issues the walker's first read. The input stalls for
    // the whole walk, so no forwarding is needed.
    ili_list_ram u_list_a (
        .clk     (clk),
        .wr_en   (wr_en_a),
        .wr_addr (count_a_reg[ADDR_BITS-1:0]),
        .wr_data (wr_entry),
        .rd_addr (a_rd_addr),
        .rd_data (a_data)
    );

    ili_list_ram u_list_b (
        .clk     (clk),
        .wr_en   (wr_en_b),
        .wr_addr (count_b_reg[ADDR_BITS-1:0]),
        .wr_data (wr_entry),
        .rd_addr (b_rd_addr),
        .rd_data (b_data)
    );

    ili_walk u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .a_data    (a_data),
        .b_data    (b_data),
        .a_rd_addr (a_rd_addr),
        .b_rd_addr (b_rd_addr),
        .out_free  (out_free),
        .push      (push),
        .push_item (push_item),
        .busy      (busy)
    );

    assign item_stall = busy;

    // The output register takes a new result when empty or when its transfer completes.
    assign out_free       = !out_valid_reg || !result_stall;
    assign out_valid_next = push || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_a_reg   <= count_a_next;
            count_b_reg   <= count_b_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_reg <= push_item;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
